// ===== rtl/grc_pkg.sv =====
package grc_pkg;

    localparam int NUM_SLOTS_DEF = 4;
    localparam int MAX_SLOTS     = 8;

    localparam logic [7:0] THRESH_RESET = 8'h30;

    localparam int N_ANALOG = 8;
    localparam int BYTE_W   = 8;
    localparam int DIG_W    = 16;
    localparam int AN_W     = N_ANALOG * BYTE_W;
    localparam int N_AXES   = 4;
    localparam int AXIS_W   = 16;
    localparam int STICK_W  = N_AXES * AXIS_W;
    localparam int CNT_W    = 3;
    localparam int CNT_SAT  = 7;

    typedef struct packed {
        logic        [1:0]  pad_slot;
        logic               pad_present;
        logic        [3:0]  dpad_bits;
        logic        [11:0] other_digital_bits;
        logic        [47:0] face_keys;
        logic        [7:0]  trigger_left;
        logic        [7:0]  trigger_right;
        logic signed [15:0] left_stick_x;
        logic signed [15:0] left_stick_y;
        logic signed [15:0] right_stick_x;
        logic signed [15:0] right_stick_y;
    } t_in_item;

    typedef struct packed {
        logic [DIG_W-1:0]    slot_digital;
        logic [DIG_W-1:0]    slot_new_digital;
        logic [AN_W-1:0]     slot_analog;
        logic [N_ANALOG-1:0] slot_new_analog;
        logic [DIG_W-1:0]    all_digital;
        logic [DIG_W-1:0]    all_new_digital;
        logic [AN_W-1:0]     all_analog;
        logic [N_ANALOG-1:0] all_new_analog;
        logic [STICK_W-1:0]  all_sticks;
        logic [CNT_W-1:0]    present_count;
    } t_out_item;

    // stored state of one slot
    typedef struct packed {
        logic                present;
        logic [DIG_W-1:0]    dig;
        logic [DIG_W-1:0]    new_dig;
        logic [AN_W-1:0]     analog;
        logic [N_ANALOG-1:0] prev_bits;
        logic [N_ANALOG-1:0] new_bits;
        logic [STICK_W-1:0]  sticks;
    } t_slot_state;

endpackage

// ===== rtl/grc_stream_if.sv =====
interface grc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/grc_slot_update.sv =====
module grc_slot_update (
    input  grc_pkg::t_in_item    i_item,
    input  logic [7:0]           i_threshold,
    input  grc_pkg::t_slot_state i_prev,
    output grc_pkg::t_slot_state o_next
);

    logic [grc_pkg::AN_W-1:0]     w_raw;
    logic [grc_pkg::AN_W-1:0]     w_an;
    logic [grc_pkg::N_ANALOG-1:0] w_bits;
    logic [grc_pkg::DIG_W-1:0]    w_dig;

    assign w_raw = {i_item.trigger_right, i_item.trigger_left, i_item.face_keys};
    assign w_dig = {i_item.other_digital_bits, i_item.dpad_bits};

    // strict compare against threshold per analog byte
    always_comb begin
        w_an   = '0;
        w_bits = '0;
        for (int b = 0; b < grc_pkg::N_ANALOG; b++) begin
            if (w_raw[b*grc_pkg::BYTE_W +: grc_pkg::BYTE_W] > i_threshold) begin
                w_an[b*grc_pkg::BYTE_W +: grc_pkg::BYTE_W] =
                    w_raw[b*grc_pkg::BYTE_W +: grc_pkg::BYTE_W];
                w_bits[b] = 1'b1;
            end
        end
    end

    always_comb begin
        o_next = '0;
        if (i_item.pad_present) begin
            o_next.present   = 1'b1;
            o_next.dig       = w_dig;
            o_next.new_dig   = w_dig & ~i_prev.dig;
            o_next.analog    = w_an;
            o_next.prev_bits = w_bits;
            o_next.new_bits  = w_bits & ~i_prev.prev_bits;
            o_next.sticks    = {i_item.right_stick_y, i_item.right_stick_x,
                                i_item.left_stick_y, i_item.left_stick_x};
        end
    end

endmodule

// ===== rtl/grc_merge.sv =====
module grc_merge #(
    parameter int NUM_SLOTS = grc_pkg::NUM_SLOTS_DEF
) (
    input  grc_pkg::t_slot_state          i_slots [NUM_SLOTS],
    output logic [grc_pkg::DIG_W-1:0]     o_all_digital,
    output logic [grc_pkg::DIG_W-1:0]     o_all_new_digital,
    output logic [grc_pkg::AN_W-1:0]      o_all_analog,
    output logic [grc_pkg::N_ANALOG-1:0]  o_all_new_analog,
    output logic [grc_pkg::STICK_W-1:0]   o_all_sticks,
    output logic [grc_pkg::CNT_W-1:0]     o_present_count
);

    localparam int SUM_CNT_W = $clog2(NUM_SLOTS + 1);

    logic [SUM_CNT_W-1:0] w_cnt;

    always_comb begin
        o_all_digital     = '0;
        o_all_new_digital = '0;
        o_all_analog      = '0;
        o_all_new_analog  = '0;
        o_all_sticks      = '0;
        w_cnt             = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            o_all_digital     = o_all_digital | i_slots[s].dig;
            o_all_new_digital = o_all_new_digital | i_slots[s].new_dig;
            o_all_new_analog  = o_all_new_analog | i_slots[s].new_bits;
            for (int b = 0; b < grc_pkg::N_ANALOG; b++) begin
                if (i_slots[s].analog[b*grc_pkg::BYTE_W +: grc_pkg::BYTE_W] >
                    o_all_analog[b*grc_pkg::BYTE_W +: grc_pkg::BYTE_W]) begin
                    o_all_analog[b*grc_pkg::BYTE_W +: grc_pkg::BYTE_W] =
                        i_slots[s].analog[b*grc_pkg::BYTE_W +: grc_pkg::BYTE_W];
                end
            end
            // 16-bit lanes wrap naturally
            for (int k = 0; k < grc_pkg::N_AXES; k++) begin
                o_all_sticks[k*grc_pkg::AXIS_W +: grc_pkg::AXIS_W] =
                    o_all_sticks[k*grc_pkg::AXIS_W +: grc_pkg::AXIS_W] +
                    i_slots[s].sticks[k*grc_pkg::AXIS_W +: grc_pkg::AXIS_W];
            end
            w_cnt = w_cnt + SUM_CNT_W'(i_slots[s].present);
        end
    end

    // saturate at 7 when more than seven slots are present
    always_comb begin
        if (int'(w_cnt) > grc_pkg::CNT_SAT) begin
            o_present_count = grc_pkg::CNT_W'(grc_pkg::CNT_SAT);
        end else begin
            o_present_count = grc_pkg::CNT_W'(w_cnt);
        end
    end

endmodule

// ===== rtl/gamepad_report_conditioner.sv =====
// An accepted report is registered in s1, then in out, which drives o_out.
// Throughput: one report per cycle while o_out is ready, back-to-back without bubbles,
//   since the slot update and the combined view come out of one pass.
// Reset (i_rst_n low, synchronous): both registers emptied, all slot state
//   cleared, analog threshold back to 0x30.
module gamepad_report_conditioner #(
    parameter int NUM_SLOTS = grc_pkg::NUM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    grc_stream_if.sink        i_in,
    grc_stream_if.source      o_out
);

    // Pipeline:
    //   s1  - input register holding the raw report
    //   out - result register. Threshold / edge detect against the slot's
    //         stored state and the combined view over all slots are formed
    //         from the s1 beat in one pass; the merge sees the s1 slot's new
    //         state in place of its stored one. Slot state is written as
    //         the beat moves from s1 to out.
    // s1 loads when it is empty or out is empty or advancing, so one more beat is
    // taken while a result waits at o_out.

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // threshold register
    logic [7:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= grc_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // stage handshakes
    logic r_s1_v, r_out_v;
    logic w_s1_en, w_out_en;

    assign w_out_en = !r_out_v || o_out.ready;
    assign w_s1_en  = !r_s1_v || w_out_en;

    assign i_in.ready  = w_s1_en;
    assign o_out.valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_v <= i_in.valid;
            end
            if (w_out_en) begin
                r_out_v <= r_s1_v;
            end
        end
    end

    // s1: raw report
    grc_pkg::t_in_item r_s1_item;

    always_ff @(posedge i_clk) begin
        if (w_s1_en) begin
            r_s1_item <= i_in.data;
        end
    end

    // slot select; slot numbers at or past NUM_SLOTS are ignored
    logic             w_in_range;
    logic [IDX_W-1:0] w_idx;

    assign w_in_range = int'(r_s1_item.pad_slot) < NUM_SLOTS;
    assign w_idx      = IDX_W'(r_s1_item.pad_slot);

    // per-slot stored state
    grc_pkg::t_slot_state r_slot [NUM_SLOTS];
    grc_pkg::t_slot_state w_prev;
    grc_pkg::t_slot_state w_next;

    always_comb begin
        w_prev = '0;
        if (w_in_range) begin
            w_prev = r_slot[w_idx];
        end
    end

    grc_slot_update u_slot_update (
        .i_item      (r_s1_item),
        .i_threshold (r_thresh),
        .i_prev      (w_prev),
        .o_next      (w_next)
    );

    // absent pad gives an all-zero next state, which is the clear
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!i_rst_n) begin
                r_slot[s] <= '0;
            end else if (w_out_en && r_s1_v && w_in_range && int'(w_idx) == s) begin
                r_slot[s] <= w_next;
            end
        end
    end

    // slots as the merge sees them: the s1 slot already carries its update
    grc_pkg::t_slot_state w_merge_slot [NUM_SLOTS];

    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            w_merge_slot[s] = r_slot[s];
            if (w_in_range && int'(w_idx) == s) begin
                w_merge_slot[s] = w_next;
            end
        end
    end

    // slot-side result fields, zero for an ignored slot
    grc_pkg::t_slot_state w_slot_res;

    assign w_slot_res = w_in_range ? w_next : '0;

    // combined view over all slots
    logic [grc_pkg::DIG_W-1:0]    w_all_dig;
    logic [grc_pkg::DIG_W-1:0]    w_all_new_dig;
    logic [grc_pkg::AN_W-1:0]     w_all_an;
    logic [grc_pkg::N_ANALOG-1:0] w_all_new_an;
    logic [grc_pkg::STICK_W-1:0]  w_all_sticks;
    logic [grc_pkg::CNT_W-1:0]    w_cnt;

    grc_merge #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_merge (
        .i_slots           (w_merge_slot),
        .o_all_digital     (w_all_dig),
        .o_all_new_digital (w_all_new_dig),
        .o_all_analog      (w_all_an),
        .o_all_new_analog  (w_all_new_an),
        .o_all_sticks      (w_all_sticks),
        .o_present_count   (w_cnt)
    );

    // output register
    grc_pkg::t_out_item r_out_item;
    grc_pkg::t_out_item n_out_item;

    always_comb begin
        n_out_item.slot_digital     = w_slot_res.dig;
        n_out_item.slot_new_digital = w_slot_res.new_dig;
        n_out_item.slot_analog      = w_slot_res.analog;
        n_out_item.slot_new_analog  = w_slot_res.new_bits;
        n_out_item.all_digital      = w_all_dig;
        n_out_item.all_new_digital  = w_all_new_dig;
        n_out_item.all_analog       = w_all_an;
        n_out_item.all_new_analog   = w_all_new_an;
        n_out_item.all_sticks       = w_all_sticks;
        n_out_item.present_count    = w_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.data = r_out_item;

endmodule

// ===== rtl/grc_checker.sv =====
module grc_checker #(
    parameter int NUM_SLOTS = grc_pkg::NUM_SLOTS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input grc_pkg::t_out_item i_out_data
);

    // held result must not move
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("valid result right after reset");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_out_data.present_count) <= NUM_SLOTS))
        else $error("present count above slot count");

    // slot word is part of the combined word, new presses are part of both
    a_dig_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (((i_out_data.slot_digital & ~i_out_data.all_digital) == '0) &&
             ((i_out_data.slot_new_digital & ~i_out_data.all_new_digital) == '0) &&
             ((i_out_data.slot_new_digital & ~i_out_data.slot_digital) == '0)))
        else $error("slot digital not covered by combined view");

    a_an_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_out_data.slot_new_analog & ~i_out_data.all_new_analog) == '0))
        else $error("slot analog press not covered by combined view");

endmodule

bind gamepad_report_conditioner grc_checker #(
    .NUM_SLOTS (NUM_SLOTS)
) u_grc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
